[rtl/core/i2c_eeprom_master_defines.svh]
// ----------------------------------------------------------------------------
// i2c_eeprom_master_defines.svh
// Assertion macros shared by the EEPROM master RTL. With SYNTH defined the
// macros expand to nothing.
// ----------------------------------------------------------------------------
`ifndef I2C_EEPROM_MASTER_DEFINES_SVH
`define I2C_EEPROM_MASTER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication: whenever ante holds, cons holds too
`define EM_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the cycle after
`define EM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define EM_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define EM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/core/i2c_em_pkg.sv]
// ----------------------------------------------------------------------------
// i2c_em_pkg
// Types and constants of the serial EEPROM bus master: transaction payloads,
// configuration registers, register indexes and sequencer phases.
// ----------------------------------------------------------------------------
package i2c_em_pkg;

   // Configuration register widths
   localparam int HALF_W     = 10;
   localparam int WAIT_CFG_W = 24;
   localparam int DEV_W      = 7;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_BIT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_WAIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE     = 2'd2;

   // Register reset values
   localparam logic [HALF_W-1:0]     HALF_RESET = 10'd4;
   localparam logic [WAIT_CFG_W-1:0] WAIT_RESET = 24'd1000000;
   localparam logic [DEV_W-1:0]      DEV_RESET  = 7'h50;

   // Read/write bit appended to the device address
   localparam logic RW_WRITE = 1'b0;
   localparam logic RW_READ  = 1'b1;

   // Command codes
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Last bit position of a byte slot (two half periods per bit)
   localparam logic [3:0] BIT_LAST = 4'd15;

   typedef struct packed {
      logic              request_valid;
      logic              command;
      logic [7:0]        mem_address;
      logic [7:0]        byte_count;
      logic [7:0]        write_data;
      logic              sda_in;
   } req_type;

   typedef struct packed {
      logic              scl;
      logic              sda_out;
      logic              busy_res;
      logic              data_request;
      logic              read_valid;
      logic [7:0]        read_data;
      logic              last_byte;
      logic              ack_missing;
   } rsp_type;

   typedef struct packed {
      logic [HALF_W-1:0]     half_bit_ticks;
      logic [WAIT_CFG_W-1:0] write_wait_ticks;
      logic [DEV_W-1:0]      device_address;
   } cfg_type;

   typedef enum logic [4:0] {
      PH_IDLE     = 5'd0,
      PH_START    = 5'd1,
      PH_RESTART  = 5'd2,
      PH_TX_DEVW  = 5'd3,
      PH_TX_ADDR  = 5'd4,
      PH_TX_DEVR  = 5'd5,
      PH_TX_DATA  = 5'd6,
      PH_ACK_DEVW = 5'd7,
      PH_ACK_ADDR = 5'd8,
      PH_ACK_DEVR = 5'd9,
      PH_ACK_DATA = 5'd10,
      PH_RX       = 5'd11,
      PH_MACK     = 5'd12,
      PH_STOP     = 5'd13,
      PH_WAIT     = 5'd14
   } phase_type;

endpackage

[rtl/core/i2c_em_csr.sv]
// ----------------------------------------------------------------------------
// i2c_em_csr
// Configuration registers: bus timing, write programming wait and the
// seven bit device address.
// ----------------------------------------------------------------------------
module i2c_em_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [i2c_em_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [i2c_em_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output i2c_em_pkg::cfg_type                 cfg
);
   import i2c_em_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HALF_BIT:   cfg_in.half_bit_ticks   = csr_write_data[HALF_W-1:0];
            CSR_WRITE_WAIT: cfg_in.write_wait_ticks = csr_write_data[WAIT_CFG_W-1:0];
            CSR_DEVICE:     cfg_in.device_address   = csr_write_data[DEV_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_bit_ticks   <= HALF_RESET;
         cfg_ff.write_wait_ticks <= WAIT_RESET;
         cfg_ff.device_address   <= DEV_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/i2c_em_seq.sv]
// ----------------------------------------------------------------------------
// i2c_em_seq
// Bus phase sequencer. Holds the phase, tick and bit counters and the byte
// datapath; computes the line levels and flags of one tick and advances the
// state when the tick is taken.
// ----------------------------------------------------------------------------
module i2c_em_seq #(
   parameter int WAIT_WIDTH = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  i2c_em_pkg::req_type   item,
   input  i2c_em_pkg::cfg_type   cfg,
   output i2c_em_pkg::rsp_type   result
);
   import i2c_em_pkg::*;

   localparam int CNT_W = (WAIT_WIDTH > HALF_W) ? WAIT_WIDTH : HALF_W;

   // State registers
   phase_type        phase_ff, phase_in;
   logic [3:0]       bit_ff, bit_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       bytes_ff, bytes_in;
   logic [7:0]       shift_ff, shift_in;
   logic [7:0]       addr_ff, addr_in;
   logic             cmd_ff, cmd_in;

   // State as seen by this tick, after a possible start of a transaction
   logic             load;
   phase_type        ph_e;
   logic [3:0]       bit_e;
   logic [CNT_W-1:0] cnt_e;
   logic [7:0]       bytes_e;
   logic [7:0]       shift_e;

   logic [WAIT_WIDTH-1:0] wait_sat;
   logic                  wait_zero;
   logic [CNT_W-1:0]      len;
   logic [CNT_W:0]        cnt_inc;
   logic                  end_tick;
   logic [7:0]            shift_rx;
   logic                  more_bytes;
   logic                  scl, sda, dreq, rvalid, last, nack;
   logic [7:0]            rdata;

   // Clamp the programming wait to the counter range
   generate
      if (WAIT_WIDTH >= WAIT_CFG_W) begin : g_wait_wide
         assign wait_sat = WAIT_WIDTH'(cfg.write_wait_ticks);
      end else begin : g_wait_narrow
         assign wait_sat = (|cfg.write_wait_ticks[WAIT_CFG_W-1:WAIT_WIDTH]) ? '1 :
                           cfg.write_wait_ticks[WAIT_WIDTH-1:0];
      end
   endgenerate

   assign wait_zero = (wait_sat == '0);

   // Take a new transaction when idle
   always_comb begin
      load    = (phase_ff == PH_IDLE) && item.request_valid;
      ph_e    = load ? PH_START : phase_ff;
      bit_e   = load ? 4'd0 : bit_ff;
      cnt_e   = load ? '0 : cnt_ff;
      bytes_e = load ? item.byte_count : bytes_ff;
      shift_e = load ? {cfg.device_address, RW_WRITE} : shift_ff;
      addr_in = load ? item.mem_address : addr_ff;
      cmd_in  = load ? item.command : cmd_ff;
   end

   // Step length and end of step
   always_comb begin
      if (ph_e == PH_WAIT) begin
         len = wait_zero ? CNT_W'(1) : CNT_W'(wait_sat);
      end else begin
         len = (cfg.half_bit_ticks == '0) ? CNT_W'(1) : CNT_W'(cfg.half_bit_ticks);
      end
      cnt_inc  = {1'b0, cnt_e} + (CNT_W+1)'(1);
      end_tick = (cnt_inc >= {1'b0, len});
   end

   assign shift_rx   = {shift_e[6:0], item.sda_in};
   assign more_bytes = (bytes_e != 8'd0);

   // Next phase, bit position and tick count
   always_comb begin
      phase_in = ph_e;
      bit_in   = bit_e;
      cnt_in   = cnt_e;
      unique case (ph_e) inside
         PH_IDLE: begin
            phase_in = PH_IDLE;
         end
         PH_START: begin
            if (!end_tick) begin
               cnt_in = cnt_inc[CNT_W-1:0];
            end else if (bit_e != 4'd0) begin
               phase_in = PH_TX_DEVW;
               bit_in   = 4'd0;
               cnt_in   = '0;
            end else begin
               bit_in = bit_e + 4'd1;
               cnt_in = '0;
            end
         end
         PH_RESTART: begin
            if (!end_tick) begin
               cnt_in = cnt_inc[CNT_W-1:0];
            end else if (bit_e >= 4'd2) begin
               phase_in = PH_TX_DEVR;
               bit_in   = 4'd0;
               cnt_in   = '0;
            end else begin
               bit_in = bit_e + 4'd1;
               cnt_in = '0;
            end
         end
         PH_TX_DEVW, PH_TX_ADDR, PH_TX_DEVR, PH_TX_DATA: begin
            if (!end_tick) begin
               cnt_in = cnt_inc[CNT_W-1:0];
            end else if (bit_e == BIT_LAST) begin
               unique case (ph_e) inside
                  PH_TX_DEVW: phase_in = PH_ACK_DEVW;
                  PH_TX_ADDR: phase_in = PH_ACK_ADDR;
                  PH_TX_DEVR: phase_in = PH_ACK_DEVR;
                  default:    phase_in = PH_ACK_DATA;
               endcase
               bit_in = 4'd0;
               cnt_in = '0;
            end else begin
               bit_in = bit_e + 4'd1;
               cnt_in = '0;
            end
         end
         PH_ACK_DEVW, PH_ACK_ADDR, PH_ACK_DEVR, PH_ACK_DATA: begin
            if (!end_tick) begin
               cnt_in = cnt_inc[CNT_W-1:0];
            end else if (!bit_e[0]) begin
               bit_in = 4'd1;
               cnt_in = '0;
            end else begin
               bit_in = 4'd0;
               cnt_in = '0;
               if (ph_e == PH_ACK_DEVW) begin
                  phase_in = PH_TX_ADDR;
               end else if (ph_e == PH_ACK_DEVR) begin
                  phase_in = more_bytes ? PH_RX : PH_STOP;
               end else if (ph_e == PH_ACK_ADDR && cmd_in == CMD_READ) begin
                  phase_in = PH_RESTART;
               end else begin
                  phase_in = more_bytes ? PH_TX_DATA : PH_STOP;
               end
            end
         end
         PH_RX: begin
            if (!end_tick) begin
               cnt_in = cnt_inc[CNT_W-1:0];
            end else if (bit_e == BIT_LAST) begin
               phase_in = PH_MACK;
               bit_in   = 4'd0;
               cnt_in   = '0;
            end else begin
               bit_in = bit_e + 4'd1;
               cnt_in = '0;
            end
         end
         PH_MACK: begin
            if (!end_tick) begin
               cnt_in = cnt_inc[CNT_W-1:0];
            end else if (!bit_e[0]) begin
               bit_in = 4'd1;
               cnt_in = '0;
            end else begin
               phase_in = more_bytes ? PH_RX : PH_STOP;
               bit_in   = 4'd0;
               cnt_in   = '0;
            end
         end
         PH_STOP: begin
            if (!end_tick) begin
               cnt_in = cnt_inc[CNT_W-1:0];
            end else if (bit_e >= 4'd2) begin
               phase_in = (cmd_in == CMD_WRITE && !wait_zero) ? PH_WAIT : PH_IDLE;
               bit_in   = 4'd0;
               cnt_in   = '0;
            end else begin
               bit_in = bit_e + 4'd1;
               cnt_in = '0;
            end
         end
         PH_WAIT: begin
            if (end_tick) begin
               phase_in = PH_IDLE;
               bit_in   = 4'd0;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_inc[CNT_W-1:0];
            end
         end
         default: begin
            phase_in = PH_IDLE;
            bit_in   = 4'd0;
            cnt_in   = '0;
         end
      endcase
   end

   // Line levels, flags and byte datapath
   always_comb begin
      scl      = 1'b1;
      sda      = 1'b1;
      dreq     = 1'b0;
      rvalid   = 1'b0;
      rdata    = 8'd0;
      last     = 1'b0;
      nack     = 1'b0;
      shift_in = shift_e;
      bytes_in = bytes_e;
      unique case (ph_e) inside
         PH_IDLE, PH_WAIT: begin
            scl = 1'b1;
         end
         PH_START: begin
            sda = (bit_e == 4'd0);
         end
         PH_RESTART: begin
            scl = (bit_e != 4'd0);
            sda = (bit_e != 4'd2);
            if (end_tick && bit_e >= 4'd2) begin
               shift_in = {cfg.device_address, RW_READ};
            end
         end
         PH_TX_DEVW, PH_TX_ADDR, PH_TX_DEVR, PH_TX_DATA: begin
            scl = bit_e[0];
            sda = shift_e[~bit_e[3:1]];
         end
         PH_ACK_DEVW, PH_ACK_ADDR, PH_ACK_DEVR, PH_ACK_DATA: begin
            scl = bit_e[0];
            if (end_tick && bit_e[0]) begin
               nack = item.sda_in;
               if (ph_e == PH_ACK_DEVW) begin
                  shift_in = addr_in;
               end else if (ph_e == PH_ACK_DEVR) begin
                  shift_in = shift_e;
               end else if (ph_e == PH_ACK_ADDR && cmd_in == CMD_READ) begin
                  shift_in = shift_e;
               end else if (more_bytes) begin
                  dreq     = 1'b1;
                  last     = (bytes_e == 8'd1);
                  bytes_in = bytes_e - 8'd1;
                  shift_in = item.write_data;
               end
            end
         end
         PH_RX: begin
            scl = bit_e[0];
            if (end_tick && bit_e[0]) begin
               shift_in = shift_rx;
            end
            if (end_tick && bit_e == BIT_LAST) begin
               rvalid   = 1'b1;
               rdata    = shift_rx;
               last     = (bytes_e == 8'd1);
               bytes_in = bytes_e - 8'd1;
            end
         end
         PH_MACK: begin
            scl = bit_e[0];
            sda = !more_bytes;
         end
         PH_STOP: begin
            scl = (bit_e != 4'd0);
            sda = (bit_e == 4'd2);
         end
         default: begin
            scl = 1'b1;
         end
      endcase
   end

   // Result of this tick
   always_comb begin
      result.scl          = scl;
      result.sda_out      = sda;
      result.busy_res     = !(phase_in == PH_IDLE && scl && sda && !dreq && !rvalid && !nack);
      result.data_request = dreq;
      result.read_valid   = rvalid;
      result.read_data    = rdata;
      result.last_byte    = last;
      result.ack_missing  = nack;
   end

   // Advance the state on a taken tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bit_ff   <= 4'd0;
         cnt_ff   <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         bytes_ff <= bytes_in;
         shift_ff <= shift_in;
         addr_ff  <= addr_in;
         cmd_ff   <= cmd_in;
      end
   end

endmodule

[rtl/core/i2c_eeprom_master.sv]
// ----------------------------------------------------------------------------
// i2c_eeprom_master
// Serial EEPROM bus master: one request transaction per timing tick in,
// one result transaction per tick out with the SCL/SDA levels and flags.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one tick per transaction: a start request with command,
//   memory address and byte count, the next write byte and the sampled SDA.
//   rsp_* returns one transaction per tick: SCL, SDA drive, busy, data
//   request, received byte and acknowledge status.
//   csr_* writes the half bit length, write programming wait and device
//   address; write it only while the block is idle.
//   A tick's result passes through the input register, then the result register.
//   Throughput: one tick per cycle while the result is not stalled, set by
//   the single sequencer step between those two registers.
//   Reset: the sequencer returns to idle with both lines released and the
//   registers take their defaults (4, 1000000, 0x50).
//   When rsp_stall is high the result holds; one more tick is buffered in
//   the input register, after which req_stall rises until the result is taken.
// ----------------------------------------------------------------------------
`include "i2c_eeprom_master_defines.svh"

module i2c_eeprom_master #(
   parameter int WAIT_WIDTH = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  i2c_em_pkg::req_type                req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output i2c_em_pkg::rsp_type                rsp_data,
   input  logic                               csr_write_enable,
   input  logic [i2c_em_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [i2c_em_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import i2c_em_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type step_result;
   cfg_type cfg;
   logic    accept;
   logic    advance;

   i2c_em_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   i2c_em_seq #(
      .WAIT_WIDTH (WAIT_WIDTH)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_data_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   // Move a tick from the input register to the result register
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   // Hold the valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture payloads
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `EM_ASSERT_IMPLIES(a_one_event, clock, reset, rsp_valid_ff, !(rsp_data_ff.data_request && rsp_data_ff.read_valid), "data request and read byte in one tick")
   `EM_ASSERT_IMPLIES(a_last_flag, clock, reset, rsp_valid_ff && rsp_data_ff.last_byte, rsp_data_ff.data_request || rsp_data_ff.read_valid, "last byte without a byte")
   `EM_ASSERT_IMPLIES(a_ack_high, clock, reset, rsp_valid_ff && rsp_data_ff.ack_missing, rsp_data_ff.scl && rsp_data_ff.busy_res, "acknowledge sampled outside SCL high")
   `EM_ASSERT_NEXT(a_step_lands, clock, reset, advance, rsp_valid_ff, "sequencer step lost its result")

endmodule

[test/i2c_em_checker.sv]
// ----------------------------------------------------------------------------
// i2c_em_checker
// Watches the tick and result channels of the EEPROM bus master, runs its
// own model of the bus sequencer on every accepted tick, and compares each
// accepted result field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module i2c_em_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  i2c_em_pkg::req_type               req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  i2c_em_pkg::rsp_type               rsp_data,
   input  logic                              csr_write_enable,
   input  logic [i2c_em_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [i2c_em_pkg::CSR_DATA_W-1:0] csr_write_data,
   output int                                fail_count,
   output int                                pending,
   output logic                              seq_idle
);
   timeunit 1ns;
   timeprecision 1ps;
   import i2c_em_pkg::*;

   // Register copies
   logic [HALF_W-1:0]     half_q;
   logic [WAIT_CFG_W-1:0] wait_q;
   logic [DEV_W-1:0]      dev_q;

   // Sequencer state
   phase_type             ph;
   logic [WAIT_CFG_W-1:0] tcnt;
   logic [3:0]            bidx;
   logic [7:0]            left;
   logic [7:0]            shreg;
   logic [7:0]            maddr;
   logic                  cmd_q;

   // Predicted line levels and flags, oldest first
   rsp_type               bus_ticks_due[$];

   function automatic void enter(phase_type nxt, logic [3:0] step);
      ph   = nxt;
      bidx = step;
      tcnt = '0;
   endfunction

   // Advance the sequencer by one tick and return the levels it drives
   function automatic rsp_type step_tick(req_type t);
      rsp_type     r;
      logic        scl, sda, dreq, rvld, last, nack, done;
      logic [7:0]  rdata;
      logic [24:0] len;
      scl   = 1'b1;
      sda   = 1'b1;
      dreq  = 1'b0;
      rvld  = 1'b0;
      rdata = 8'd0;
      last  = 1'b0;
      nack  = 1'b0;
      // a zero half period behaves as one tick
      len = (half_q == '0) ? 25'd1 : 25'(half_q);

      // take a request only when idle
      if (ph == PH_IDLE && t.request_valid) begin
         cmd_q = t.command;
         maddr = t.mem_address;
         left  = t.byte_count;
         shreg = {dev_q, RW_WRITE};
         enter(PH_START, 4'd0);
      end
      if (ph == PH_WAIT)
         len = (wait_q == '0) ? 25'd1 : 25'(wait_q);
      done = (25'(tcnt) + 25'd1 >= len);

      case (ph)
         PH_START: begin
            sda = (bidx == 4'd0);
            if (done) begin
               if (bidx >= 4'd1) enter(PH_TX_DEVW, 4'd0);
               else enter(PH_START, bidx + 4'd1);
            end else tcnt++;
         end
         PH_RESTART: begin
            scl = (bidx != 4'd0);
            sda = (bidx != 4'd2);
            if (done) begin
               if (bidx >= 4'd2) begin
                  shreg = {dev_q, RW_READ};
                  enter(PH_TX_DEVR, 4'd0);
               end else enter(PH_RESTART, bidx + 4'd1);
            end else tcnt++;
         end
         PH_TX_DEVW, PH_TX_ADDR, PH_TX_DEVR, PH_TX_DATA: begin
            scl = bidx[0];
            sda = shreg[3'd7 - bidx[3:1]];
            if (done) begin
               // each send phase is followed by its acknowledge slot
               if (bidx == BIT_LAST) enter(phase_type'(ph + 5'd4), 4'd0);
               else enter(ph, bidx + 4'd1);
            end else tcnt++;
         end
         PH_ACK_DEVW, PH_ACK_ADDR, PH_ACK_DEVR, PH_ACK_DATA: begin
            scl = bidx[0];
            if (!done) tcnt++;
            else if (!bidx[0]) enter(ph, 4'd1);
            else begin
               // sample the acknowledge and pick the next byte
               nack = t.sda_in;
               if (ph == PH_ACK_DEVW) begin
                  shreg = maddr;
                  enter(PH_TX_ADDR, 4'd0);
               end else if (ph == PH_ACK_DEVR) begin
                  enter((left != 8'd0) ? PH_RX : PH_STOP, 4'd0);
               end else if (ph == PH_ACK_ADDR && cmd_q == CMD_READ) begin
                  enter(PH_RESTART, 4'd0);
               end else if (left != 8'd0) begin
                  dreq  = 1'b1;
                  last  = (left == 8'd1);
                  left  = left - 8'd1;
                  shreg = t.write_data;
                  enter(PH_TX_DATA, 4'd0);
               end else enter(PH_STOP, 4'd0);
            end
         end
         PH_RX: begin
            scl = bidx[0];
            if (!done) tcnt++;
            else begin
               // shift in on the high half of each bit
               if (bidx[0]) shreg = {shreg[6:0], t.sda_in};
               if (bidx == BIT_LAST) begin
                  rvld  = 1'b1;
                  rdata = shreg;
                  last  = (left == 8'd1);
                  left  = left - 8'd1;
                  enter(PH_MACK, 4'd0);
               end else enter(PH_RX, bidx + 4'd1);
            end
         end
         PH_MACK: begin
            // acknowledge all but the final byte
            scl = bidx[0];
            sda = (left == 8'd0);
            if (done) begin
               if (!bidx[0]) enter(PH_MACK, 4'd1);
               else enter((left != 8'd0) ? PH_RX : PH_STOP, 4'd0);
            end else tcnt++;
         end
         PH_STOP: begin
            scl = (bidx != 4'd0);
            sda = (bidx == 4'd2);
            if (done) begin
               if (bidx >= 4'd2)
                  enter((cmd_q == CMD_WRITE && wait_q != '0) ? PH_WAIT : PH_IDLE, 4'd0);
               else enter(PH_STOP, bidx + 4'd1);
            end else tcnt++;
         end
         PH_WAIT: begin
            if (done) enter(PH_IDLE, 4'd0);
            else tcnt++;
         end
         PH_IDLE: ;
         default: enter(PH_IDLE, 4'd0);
      endcase

      r.scl          = scl;
      r.sda_out      = sda;
      r.busy_res     = (ph != PH_IDLE) || !scl || !sda || dreq || rvld || nack;
      r.data_request = dreq;
      r.read_valid   = rvld;
      r.read_data    = rdata;
      r.last_byte    = last;
      r.ack_missing  = nack;
      return r;
   endfunction

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count = fail_count + 1;
      end
   endtask

   // Track registers, predict on accepted ticks, compare accepted results
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         half_q = HALF_RESET;
         wait_q = WAIT_RESET;
         dev_q  = DEV_RESET;
         ph     = PH_IDLE;
         tcnt   = '0;
         bidx   = '0;
         left   = '0;
         shreg  = '0;
         maddr  = '0;
         cmd_q  = 1'b0;
         bus_ticks_due.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_HALF_BIT:   half_q = csr_write_data[HALF_W-1:0];
               CSR_WRITE_WAIT: wait_q = csr_write_data[WAIT_CFG_W-1:0];
               CSR_DEVICE:     dev_q  = csr_write_data[DEV_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (bus_ticks_due.size() == 0) begin
               $error("result transaction with no tick outstanding");
               fail_count = fail_count + 1;
            end else begin
               want = bus_ticks_due.pop_front();
               check_field("scl", want.scl, rsp_data.scl);
               check_field("sda_out", want.sda_out, rsp_data.sda_out);
               check_field("busy_res", want.busy_res, rsp_data.busy_res);
               check_field("data_request", want.data_request, rsp_data.data_request);
               check_field("read_valid", want.read_valid, rsp_data.read_valid);
               check_field("read_data", want.read_data, rsp_data.read_data);
               check_field("last_byte", want.last_byte, rsp_data.last_byte);
               check_field("ack_missing", want.ack_missing, rsp_data.ack_missing);
            end
         end
         if (req_valid && !req_stall)
            bus_ticks_due.push_back(step_tick(req_data));
      end
      pending  = bus_ticks_due.size();
      seq_idle = (ph == PH_IDLE);
   end

endmodule

[test/tb_i2c_eeprom_master.sv]
// ----------------------------------------------------------------------------
// tb_i2c_eeprom_master
// Drives timing ticks into the EEPROM bus master: directed transfers at the
// field extremes, then random read and write transfers under several
// register settings, with random gaps and result stalls. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_i2c_eeprom_master;
   timeunit 1ns;
   timeprecision 1ps;
   import i2c_em_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 300;

   typedef enum {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   int                    fail_count;
   int                    pending;
   logic                  seq_idle;
   bit                    gaps_on;
   bit                    hold_off_req;
   int                    idle_cycles;

   always #2 clock = ~clock;

   i2c_eeprom_master u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   i2c_em_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending          (pending),
      .seq_idle         (seq_idle)
   );

   function automatic logic [7:0] fill_byte(fill_type m);
      case (m)
         FILL_ZERO: return 8'h00;
         FILL_ONES: return 8'hFF;
         default:   return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Random tick; a request bit is raised now and then only if allowed
   function automatic req_type noise_tick(bit allow_request);
      req_type t;
      t.request_valid = allow_request && ($urandom_range(0, 15) == 0);
      t.command       = 1'($urandom_range(0, 1));
      t.mem_address   = 8'($urandom_range(0, 255));
      t.byte_count    = 8'($urandom_range(0, 255));
      t.write_data    = 8'($urandom_range(0, 255));
      t.sda_in        = 1'($urandom_range(0, 1));
      return t;
   endfunction

   // Offer one tick after an optional gap and hold it until accepted
   task automatic send_tick(input req_type t);
      int gap, r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 65) gap = 0;
      else if (r < 92) gap = $urandom_range(1, 3);
      else if (r < 99) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Start one bus transaction and feed ticks until the sequencer is idle
   task automatic run_transfer(input logic cmd, input logic [7:0] addr,
                               input logic [7:0] count, input fill_type data_mode,
                               input fill_type line_mode, input bit intrude);
      req_type t;
      t = noise_tick(1'b0);
      t.request_valid = 1'b1;
      t.command       = cmd;
      t.mem_address   = addr;
      t.byte_count    = count;
      t.write_data    = fill_byte(data_mode);
      t.sda_in        = 1'(fill_byte(line_mode));
      send_tick(t);
      while (!seq_idle) begin
         t = noise_tick(intrude);
         t.write_data = fill_byte(data_mode);
         t.sda_in     = 1'(fill_byte(line_mode));
         send_tick(t);
      end
   endtask

   // Run the sequencer to idle, stop offering and collect every result
   task automatic settle();
      while (!seq_idle) send_tick(noise_tick(1'b0));
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   task automatic program_registers(input logic [HALF_W-1:0] half,
                                    input logic [WAIT_CFG_W-1:0] wait_ticks,
                                    input logic [DEV_W-1:0] dev);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_HALF_BIT;
      csr_write_data   <= CSR_DATA_W'(half);
      @(negedge clock);
      csr_index        <= CSR_WRITE_WAIT;
      csr_write_data   <= CSR_DATA_W'(wait_ticks);
      @(negedge clock);
      csr_index        <= CSR_DEVICE;
      csr_write_data   <= CSR_DATA_W'(dev);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Result stalls: short and long bursts, free stretches, one long hold
   initial begin : rsp_stall_gen
      bit hold_done;
      int r, n;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               rsp_stall <= 1'b0;
               n = $urandom_range(1, 40);
            end else begin
               rsp_stall <= 1'b1;
               if (r < 90) n = $urandom_range(1, 3);
               else if (r < 98) n = $urandom_range(4, 12);
               else n = $urandom_range(20, 60);
            end
            repeat (n) @(negedge clock);
         end
      end
   end

   // Drop the run when nothing moves for too long
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : stimulus
      int       r;
      logic [7:0] count;
      fill_type line_mode;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      gaps_on          = 1'b1;
      hold_off_req     = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Zero half period, no programming wait, highest device address
      program_registers(10'd0, 24'd0, 7'h7F);
      run_transfer(CMD_WRITE, 8'h00, 8'd0, FILL_ZERO, FILL_ZERO, 1'b0);
      run_transfer(CMD_READ, 8'hFF, 8'd0, FILL_ONES, FILL_ONES, 1'b0);
      run_transfer(CMD_WRITE, 8'h5A, 8'd3, FILL_ZERO, FILL_ONES, 1'b1);
      run_transfer(CMD_READ, 8'h00, 8'd1, FILL_ZERO, FILL_ONES, 1'b0);
      run_transfer(CMD_READ, 8'hA5, 8'd3, FILL_ZERO, FILL_ZERO, 1'b1);
      settle();

      // Shortest half period, device address zero, short programming wait
      program_registers(10'd1, 24'd7, 7'h00);
      run_transfer(CMD_WRITE, 8'h81, 8'd2, FILL_RANDOM, FILL_ZERO, 1'b1);
      run_transfer(CMD_READ, 8'h18, 8'd2, FILL_RANDOM, FILL_RANDOM, 1'b1);
      settle();

      // Random transfers under several register settings
      for (int p = 0; p < 5; p++) begin
         gaps_on = (p % 3 != 1);
         program_registers(($urandom_range(0, 3) == 0) ? 10'd0 : 10'($urandom_range(1, 2)),
                           ($urandom_range(0, 3) == 0) ? 24'd0 : 24'($urandom_range(1, 20)),
                           7'($urandom_range(0, 127)));
         for (int k = 0; k < 2; k++) begin
            // long receiver hold while ticks keep coming
            if (p == 1 && k == 0) hold_off_req = 1'b1;
            repeat ($urandom_range(0, 3)) send_tick(noise_tick(1'b0));
            r = $urandom_range(0, 99);
            if (r < 15) count = 8'd0;
            else if (r < 85) count = 8'($urandom_range(1, 2));
            else count = 8'($urandom_range(3, 6));
            r = $urandom_range(0, 99);
            if (r < 80) line_mode = FILL_RANDOM;
            else if (r < 90) line_mode = FILL_ZERO;
            else line_mode = FILL_ONES;
            run_transfer(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), count,
                         FILL_RANDOM, line_mode, 1'($urandom_range(0, 1)));
         end
         settle();
      end

      // Let any stray result surface before the verdict
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

[i2c_eeprom_master.f]
+incdir+rtl/core
rtl/core/i2c_em_pkg.sv
rtl/core/i2c_em_csr.sv
rtl/core/i2c_em_seq.sv
rtl/core/i2c_eeprom_master.sv
test/i2c_em_checker.sv
test/tb_i2c_eeprom_master.sv
